[rtl/chdec_pkg.sv]
package chdec_pkg;

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int LEFT_W   = 32;

	localparam logic [STATUS_W-1:0] ST_CONT = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [BYTE_W-1:0] CASE_BIT  = 8'h20;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} stage_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] ch);
		logic [BYTE_W-1:0] lc;
		logic [BYTE_W-1:0] dv;
		lc = ch | CASE_BIT;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			dv = ch - CH_ZERO;
			hex_value = {1'b0, dv[3:0]};
		end else if (lc >= CH_LOW_A && lc <= CH_LOW_F) begin
			dv = lc - CH_LOW_A + 8'd10;
			hex_value = {1'b0, dv[3:0]};
		end else begin
			hex_value = 5'h10;
		end
	endfunction

endpackage

[rtl/chdec_if.sv]
interface chdec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface chdec_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [1:0]  status;
	logic [31:0] chunk_left;

	modport source (output valid, output payload_valid, output payload_byte,
		output status, output chunk_left, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input status, input chunk_left, output ready);
endinterface

[rtl/chdec_inreg.sv]
module chdec_inreg (
	input  logic              clk,
	input  logic              arst_n,
	chdec_in_if.sink          body,
	input  logic              adv,
	output chdec_pkg::stage_t s1
);
	import chdec_pkg::*;

	stage_t stage_s1;

	assign body.ready = !stage_s1.valid || adv;
	assign s1 = stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (body.ready) begin
			stage_s1.valid <= body.valid;
			if (body.valid) begin
				stage_s1.data <= body.in_byte;
			end
		end
	end

endmodule

[rtl/chdec_fsm.sv]
module chdec_fsm #(
	parameter int SIZE_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chdec_pkg::stage_t s1,
	output logic              adv,
	chdec_out_if.source       result
);
	import chdec_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_SIZE, PH_EXT, PH_EXT_CR, PH_DATA, PH_AFTER, PH_AFTER_CR,
		PH_LEXT, PH_LEXT_CR, PH_TRL, PH_TRL_CR, PH_THDR, PH_THDR_CR, PH_ERROR
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [SIZE_W-1:0]   size_q, size_d, size_dec;
	logic [4:0]          hv;
	logic                err, done, pay, is_cr, is_lf, is_sep, size_zero;
	logic [63:0]         size_wide;

	logic                out_v_q;
	logic                pay_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [STATUS_W-1:0] status_q;
	logic [LEFT_W-1:0]   left_q;

	assign hv        = hex_value(s1.data);
	assign is_cr     = s1.data == CH_CR;
	assign is_lf     = s1.data == CH_LF;
	assign is_sep    = s1.data == CH_SEMI || s1.data == CH_SPACE || s1.data == CH_TAB;
	assign size_zero = size_q == '0;
	assign size_dec  = size_zero ? size_q : size_q - SIZE_W'(1);

	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		err     = 1'b0;
		done    = 1'b0;
		pay     = 1'b0;
		case (phase_q)
			PH_START: begin
				if (!hv[4]) begin
					size_d  = SIZE_W'(hv[3:0]);
					phase_d = PH_SIZE;
				end else begin
					err = 1'b1;
				end
			end
			PH_SIZE: begin
				if (!hv[4]) begin
					// overflow when any of the top four bits is set
					if (size_q[SIZE_W-1 -: 4] != 4'd0) begin
						err = 1'b1;
					end else begin
						size_d = {size_q[SIZE_W-5:0], hv[3:0]};
					end
				end else if (is_cr) begin
					phase_d = size_zero ? PH_LEXT_CR : PH_EXT_CR;
				end else if (is_lf) begin
					phase_d = size_zero ? PH_TRL : PH_DATA;
				end else if (is_sep) begin
					phase_d = size_zero ? PH_LEXT : PH_EXT;
				end else begin
					err = 1'b1;
				end
			end
			PH_EXT: begin
				if (is_cr) begin
					phase_d = PH_EXT_CR;
				end else if (is_lf) begin
					phase_d = PH_DATA;
				end
			end
			PH_EXT_CR: begin
				if (is_lf) begin
					phase_d = PH_DATA;
				end else begin
					err = 1'b1;
				end
			end
			PH_DATA: begin
				pay    = 1'b1;
				size_d = size_dec;
				if (size_dec == '0) begin
					phase_d = PH_AFTER;
				end
			end
			PH_AFTER: begin
				if (is_cr) begin
					phase_d = PH_AFTER_CR;
				end else if (is_lf) begin
					phase_d = PH_START;
				end else begin
					err = 1'b1;
				end
			end
			PH_AFTER_CR: begin
				if (is_lf) begin
					phase_d = PH_START;
				end else begin
					err = 1'b1;
				end
			end
			PH_LEXT: begin
				if (is_cr) begin
					phase_d = PH_LEXT_CR;
				end else if (is_lf) begin
					phase_d = PH_TRL;
				end
			end
			PH_LEXT_CR: begin
				if (is_lf) begin
					phase_d = PH_TRL;
				end else begin
					err = 1'b1;
				end
			end
			PH_TRL: begin
				if (is_cr) begin
					phase_d = PH_TRL_CR;
				end else if (is_lf) begin
					done = 1'b1;
				end else begin
					phase_d = PH_THDR;
				end
			end
			PH_TRL_CR: begin
				if (is_lf) begin
					done = 1'b1;
				end else begin
					err = 1'b1;
				end
			end
			PH_THDR: begin
				if (is_cr) begin
					phase_d = PH_THDR_CR;
				end else if (is_lf) begin
					phase_d = PH_TRL;
				end
			end
			PH_THDR_CR: begin
				if (is_lf) begin
					phase_d = PH_TRL;
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
		if (err) begin
			phase_d = PH_ERROR;
			size_d  = size_q;
		end else if (done) begin
			phase_d = PH_START;
			size_d  = '0;
		end
	end

	assign size_wide = 64'(size_d);
	assign adv = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			size_q   <= '0;
			out_v_q  <= 1'b0;
			pay_q    <= 1'b0;
			byte_q   <= '0;
			status_q <= ST_CONT;
			left_q   <= '0;
		end else if (adv) begin
			out_v_q <= s1.valid;
			if (s1.valid) begin
				phase_q <= phase_d;
				size_q  <= size_d;
				if (err) begin
					pay_q    <= 1'b0;
					byte_q   <= '0;
					status_q <= ST_ERR;
					left_q   <= '0;
				end else begin
					pay_q    <= pay;
					byte_q   <= pay ? s1.data : '0;
					status_q <= done ? ST_DONE : ST_CONT;
					left_q   <= size_wide[LEFT_W-1:0];
				end
			end
		end
	end

	assign result.valid         = out_v_q;
	assign result.payload_valid = pay_q;
	assign result.payload_byte  = byte_q;
	assign result.status        = status_q;
	assign result.chunk_left    = left_q;

endmodule

[rtl/http_chunked_body_decoder_unit.sv]
// A byte passes from the input register (chdec_inreg) to the result register in chdec_fsm; a result stall can hold it.
// Throughput: one byte per clock while result.ready takes each word; a stall holds the input.
// Input and result registers sit between the two handshakes; body.ready still follows result.ready combinationally.
// Reset (arst_n low, asynchronous) returns the parser to chunk start,
// clears the size counter and the sticky error, and empties both registers.
module http_chunked_body_decoder_unit #(
	parameter int SIZE_W = 32
) (
	input logic         clk,
	input logic         arst_n,
	chdec_in_if.sink    body,
	chdec_out_if.source result
);
	import chdec_pkg::*;

	stage_t s1;
	logic   adv;

	chdec_inreg u_inreg (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.adv    (adv),
		.s1     (s1)
	);

	chdec_fsm #(
		.SIZE_W (SIZE_W)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.s1     (s1),
		.adv    (adv),
		.result (result)
	);

endmodule

[rtl/chdec_check.sv]
module chdec_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        payload_valid,
	input logic [7:0]  payload_byte,
	input logic [1:0]  status,
	input logic [31:0] chunk_left
);
	import chdec_pkg::*;

	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && status == ST_ERR) begin
			err_seen_q <= 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_valid)
			&& $stable(payload_byte) && $stable(status) && $stable(chunk_left))
		else $error("result word changed while stalled");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_seen_q |-> status == ST_ERR)
		else $error("error status not sticky");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ERR |->
			!payload_valid && payload_byte == 8'd0 && chunk_left == 32'd0)
		else $error("error word carries data");

	a_pay_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> status == ST_CONT)
		else $error("payload byte with end or error status");

	a_nopay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("non-payload word with nonzero byte");

endmodule

bind http_chunked_body_decoder_unit chdec_check u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.payload_valid (result.payload_valid),
	.payload_byte  (result.payload_byte),
	.status        (result.status),
	.chunk_left    (result.chunk_left)
);

[tb/chdec_decode_check.sv]
`timescale 1ns / 1ps

module chdec_decode_check #(
	parameter int SIZE_W = 32
) (
	input logic  clk,
	input logic  arst_n,
	chdec_in_if  body,
	chdec_out_if result,
	output int   fail_count,
	output int   pending
);
	import chdec_pkg::*;

	typedef enum logic [3:0] {
		P_START, P_SIZE, P_EXT, P_EXT_CR, P_DATA, P_AFTER, P_AFTER_CR,
		P_LEXT, P_LEXT_CR, P_TRL, P_TRL_CR, P_THDR, P_THDR_CR, P_ERROR
	} phase_t;

	typedef struct packed {
		logic              pay_v;
		logic [BYTE_W-1:0] pay_b;
		logic [STATUS_W-1:0] status;
		logic [LEFT_W-1:0] left;
	} word_t;

	phase_t      phase;
	logic [63:0] size_cnt;
	word_t       expected_q[$];

	// bit 4 flags a non-hex byte
	function automatic logic [4:0] nibble_of(input logic [7:0] ch);
		logic [7:0] lc;
		lc = ch | CASE_BIT;
		if (ch >= CH_ZERO && ch <= CH_NINE)
			return {1'b0, ch[3:0]};
		if (lc >= CH_LOW_A && lc <= CH_LOW_F)
			return {1'b0, lc[3:0] + 4'd9};
		return 5'h10;
	endfunction

	task automatic report(input string msg);
		if (fail_count < 40)
			$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t       want;
		logic [7:0]  ch;
		logic [4:0]  nib;
		logic [67:0] grown;
		phase_t      nxt;
		logic        err;
		logic        done;
		logic        pay;
		if (!arst_n) begin
			phase = P_START;
			size_cnt = '0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (body.valid && body.ready) begin
				ch = body.in_byte;
				nib = nibble_of(ch);
				nxt = phase;
				err = 1'b0;
				done = 1'b0;
				pay = 1'b0;
				case (phase)
					P_START: begin
						if (!nib[4]) begin
							size_cnt = {60'd0, nib[3:0]};
							nxt = P_SIZE;
						end else
							err = 1'b1;
					end
					P_SIZE: begin
						if (!nib[4]) begin
							grown = {size_cnt, nib[3:0]};
							if ((grown >> SIZE_W) != 0)
								err = 1'b1;
							else
								size_cnt = grown[63:0];
						end else if (ch == CH_CR)
							nxt = (size_cnt == 0) ? P_LEXT_CR : P_EXT_CR;
						else if (ch == CH_LF)
							nxt = (size_cnt == 0) ? P_TRL : P_DATA;
						else if (ch == CH_SEMI || ch == CH_SPACE || ch == CH_TAB)
							nxt = (size_cnt == 0) ? P_LEXT : P_EXT;
						else
							err = 1'b1;
					end
					P_EXT: begin
						if (ch == CH_CR) nxt = P_EXT_CR;
						else if (ch == CH_LF) nxt = P_DATA;
					end
					P_EXT_CR: begin
						if (ch == CH_LF) nxt = P_DATA; else err = 1'b1;
					end
					P_DATA: begin
						pay = 1'b1;
						if (size_cnt > 0) size_cnt--;
						if (size_cnt == 0) nxt = P_AFTER;
					end
					P_AFTER: begin
						if (ch == CH_CR) nxt = P_AFTER_CR;
						else if (ch == CH_LF) nxt = P_START;
						else err = 1'b1;
					end
					P_AFTER_CR: begin
						if (ch == CH_LF) nxt = P_START; else err = 1'b1;
					end
					P_LEXT: begin
						if (ch == CH_CR) nxt = P_LEXT_CR;
						else if (ch == CH_LF) nxt = P_TRL;
					end
					P_LEXT_CR: begin
						if (ch == CH_LF) nxt = P_TRL; else err = 1'b1;
					end
					P_TRL: begin
						if (ch == CH_CR) nxt = P_TRL_CR;
						else if (ch == CH_LF) done = 1'b1;
						else nxt = P_THDR;
					end
					P_TRL_CR: begin
						if (ch == CH_LF) done = 1'b1; else err = 1'b1;
					end
					P_THDR: begin
						if (ch == CH_CR) nxt = P_THDR_CR;
						else if (ch == CH_LF) nxt = P_TRL;
					end
					P_THDR_CR: begin
						if (ch == CH_LF) nxt = P_TRL; else err = 1'b1;
					end
					default: err = 1'b1;
				endcase
				if (err) begin
					phase = P_ERROR;
					want.pay_v = 1'b0;
					want.pay_b = '0;
					want.status = ST_ERR;
					want.left = '0;
				end else begin
					if (done) begin
						nxt = P_START;
						size_cnt = '0;
					end
					phase = nxt;
					want.pay_v = pay;
					want.pay_b = pay ? ch : '0;
					want.status = done ? ST_DONE : ST_CONT;
					want.left = size_cnt[LEFT_W-1:0];
				end
				expected_q.push_back(want);
			end
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0)
					report("result word with no byte waiting for it");
				else begin
					want = expected_q.pop_front();
					if (result.payload_valid !== want.pay_v)
						report($sformatf("payload_valid %b, expected %b",
							result.payload_valid, want.pay_v));
					if (result.payload_byte !== want.pay_b)
						report($sformatf("payload_byte %h, expected %h",
							result.payload_byte, want.pay_b));
					if (result.status !== want.status)
						report($sformatf("status %0d, expected %0d",
							result.status, want.status));
					if (result.chunk_left !== want.left)
						report($sformatf("chunk_left %h, expected %h",
							result.chunk_left, want.left));
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[tb/tb_http_chunked_body_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_unit;
	import chdec_pkg::*;

	localparam int SIZE_W      = 32;
	localparam int ITEM_TARGET = 650;

	localparam logic [7:0] OPENING [23] = '{
		"1", CH_CR, CH_LF, 8'hFF, CH_CR, CH_LF,
		"0", "2", CH_SPACE, "x", CH_LF, 8'h00, CH_LF, CH_LF,
		"0", CH_SEMI, "t", CH_CR, CH_LF, "T", CH_LF, CH_CR, CH_LF
	};

	typedef enum int {
		TAIL_OVERFLOW, TAIL_BAD_SIZE, TAIL_LONE_CR, TAIL_NO_EOL, TAIL_HUGE
	} tail_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   bytes_sent = 0;
	bit   send_burst = 1'b0;
	bit   take_burst = 1'b0;

	chdec_in_if  body_if ();
	chdec_out_if result_if ();

	always #2 clk = ~clk;

	http_chunked_body_decoder_unit #(.SIZE_W(SIZE_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_if),
		.result (result_if)
	);

	chdec_decode_check #(.SIZE_W(SIZE_W)) decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.body       (body_if),
		.result     (result_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		logic [7:0] c;
		if (n < 4'd10)
			c = CH_ZERO + {4'd0, n};
		else begin
			c = CH_LOW_A + {4'd0, n - 4'd10};
			if (upper) c = c & ~CASE_BIT;
		end
		return c;
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			body_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		body_if.valid <= 1'b1;
		body_if.in_byte <= b;
		do @(posedge clk); while (!body_if.ready);
		bytes_sent++;
	endtask

	task automatic send_eol();
		if ($urandom_range(0, 1)) send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_size(input logic [63:0] value, input int zeros);
		int          nd;
		logic [63:0] v;
		nd = 0;
		v = value;
		while (v != 0) begin
			nd++;
			v = v >> 4;
		end
		repeat (zeros) send_byte(CH_ZERO);
		if (nd == 0 && zeros == 0) send_byte(CH_ZERO);
		for (int i = nd - 1; i >= 0; i--)
			send_byte(hex_char(value[i*4 +: 4], 1'($urandom_range(0, 1))));
	endtask

	task automatic send_ext();
		case ($urandom_range(0, 5))
			0: send_byte(CH_SPACE);
			1: send_byte(CH_TAB);
			2, 3: send_byte(CH_SEMI);
			default: return;
		endcase
		repeat ($urandom_range(0, 6)) send_byte(text_byte());
	endtask

	task automatic send_body();
		int size;
		repeat ($urandom_range(0, 3)) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
				: $urandom_range(1, 16);
			send_size(64'(size), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			send_ext();
			send_eol();
			repeat (size) send_byte(8'($urandom_range(0, 255)));
			send_eol();
		end
		send_size(64'd0, $urandom_range(0, 2));
		send_ext();
		send_eol();
		repeat ($urandom_range(0, 2)) begin
			send_byte(text_byte());
			repeat ($urandom_range(0, 6)) send_byte(text_byte());
			send_eol();
		end
		send_eol();
	endtask

	// result side
	initial begin
		int w;
		result_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
			w = take_burst ? 0 : $urandom_range(0, 14);
			if (w != 0) begin
				result_if.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	initial begin
		tail_t      tail;
		logic [7:0] b;
		logic [7:0] lc;
		int         n;
		body_if.valid = 1'b0;
		body_if.in_byte = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		foreach (OPENING[i]) send_byte(OPENING[i]);
		while (bytes_sent < ITEM_TARGET) send_body();

		// at most one framing error per run, since errors hold until reset; the huge-size tail makes none
		tail = tail_t'($urandom_range(0, 4));
		case (tail)
			TAIL_OVERFLOW: begin
				repeat ($urandom_range(0, 2)) send_byte(CH_ZERO);
				send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
				repeat (8)
					send_byte(hex_char(4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1))));
			end
			TAIL_BAD_SIZE: begin
				if ($urandom_range(0, 1)) send_size(64'($urandom_range(1, 255)), 0);
				do begin
					b = 8'($urandom_range(0, 255));
					lc = b | CASE_BIT;
				end while ((b >= CH_ZERO && b <= CH_NINE) ||
					(lc >= CH_LOW_A && lc <= CH_LOW_F) || b == CH_CR ||
					b == CH_LF || b == CH_SEMI || b == CH_SPACE || b == CH_TAB);
				send_byte(b);
			end
			TAIL_LONE_CR: begin
				case ($urandom_range(0, 2))
					0: send_size(64'($urandom_range(0, 4)), 0);
					1: begin
						send_size(64'd1, 0);
						send_eol();
						send_byte(8'($urandom_range(0, 255)));
					end
					default: begin
						send_size(64'd0, 0);
						send_eol();
					end
				endcase
				send_byte(CH_CR);
				send_byte(text_byte());
			end
			TAIL_NO_EOL: begin
				n = $urandom_range(1, 4);
				send_size(64'(n), 0);
				send_eol();
				repeat (n) send_byte(8'($urandom_range(0, 255)));
				send_byte(text_byte());
			end
			default: begin
				send_size(64'(32'hFFFF_FFFF - $urandom_range(0, 3)), $urandom_range(0, 2));
				send_ext();
				send_eol();
			end
		endcase
		repeat (20) send_byte(8'($urandom_range(0, 255)));
		body_if.valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[http_chunked_body_decoder_unit.f]
rtl/chdec_pkg.sv
rtl/chdec_if.sv
rtl/chdec_inreg.sv
rtl/chdec_fsm.sv
rtl/http_chunked_body_decoder_unit.sv
rtl/chdec_check.sv
tb/chdec_decode_check.sv
tb/tb_http_chunked_body_decoder_unit.sv
